// ===== hdl/srs_pkg.sv =====
// shared constants and types for the streaming find-and-replace block
// used by srs_cell, srs_seq and substring_replace_stream; no dependencies
package srs_pkg;

  localparam int unsigned CELLS      = 8;   // window depth, longest pattern
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 4;   // holds 0..CELLS
  localparam int unsigned IDX_W      = 3;   // cell index
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_BYTES = 2'd0,
    REG_PAT_LEN   = 2'd1,
    REG_REP_BYTES = 2'd2,
    REG_REP_LEN   = 2'd3
  } cfg_reg_e;

  // sequencer to cell row
  typedef struct packed {
    logic             load;
    logic             shift;
    logic [IDX_W-1:0] load_idx;
  } row_ctrl_t;

  // cell row to sequencer
  typedef struct packed {
    logic [CELLS-1:0]  hit_here;
    logic [CELLS-1:0]  hit_prev;
    logic [BYTE_W-1:0] head;
  } row_stat_t;

endpackage

// ===== hdl/srs_cell.sv =====
// one window cell: holds a byte, shifts toward cell zero, compares with the pattern
// depends on srs_pkg
module srs_cell (
  input  logic                      clk_i,
  input  logic                      load_en_i,
  input  logic                      shift_en_i,
  input  logic [srs_pkg::BYTE_W-1:0] load_byte_i,
  input  logic [srs_pkg::BYTE_W-1:0] next_byte_i,
  input  logic [srs_pkg::BYTE_W-1:0] pat_here_i,
  input  logic [srs_pkg::BYTE_W-1:0] pat_prev_i,
  output logic [srs_pkg::BYTE_W-1:0] byte_o,
  output logic                      hit_here_o,
  output logic                      hit_prev_o
);
  import srs_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (load_en_i) begin
      byte_d = load_byte_i;
    end else if (shift_en_i) begin
      byte_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // compare at own position and at the position after a shift
  assign byte_o     = byte_q;
  assign hit_here_o = (byte_q == pat_here_i);
  assign hit_prev_o = (byte_q == pat_prev_i);

endmodule

// ===== hdl/srs_seq.sv =====
// sequencer: window fill count, prefix decisions, replacement and flush, result register
// depends on srs_pkg; drives the cell row through row_ctrl_t
module srs_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic [srs_pkg::LEN_W-1:0]     pat_len_i,
  input  logic [srs_pkg::LEN_W-1:0]     rep_len_i,
  input  logic [srs_pkg::CFG_DATA_W-1:0] rep_bytes_i,
  input  srs_pkg::row_stat_t            row_stat_i,
  output srs_pkg::row_ctrl_t            row_ctrl_o,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_end_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [srs_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          out_valid_o,
  output logic                          run_last_o,
  output logic                          out_end_o
);
  import srs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REPL,
    S_FLUSH,
    S_MARK
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              end_q, end_d;
  logic [IDX_W-1:0]  ridx_q, ridx_d;
  logic              res_valid_q, res_valid_d;
  logic [BYTE_W-1:0] ob_q, ob_d;
  logic              ov_q, ov_d;
  logic              rl_q, rl_d;
  logic              oe_q, oe_d;

  logic [CELLS-1:0]  vmask, vmask_sh;
  logic [CNT_W-1:0]  cnt_m1;
  logic              pre, pre_sh, match_sh, rep_nz, out_free;
  logic              emit, e_val, e_last;
  logic [BYTE_W-1:0] e_byte;

  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign rep_nz   = (rep_len_i != '0);
  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      vmask[i]    = (CNT_W'(i) < cnt_q);
      vmask_sh[i] = (i != 0) && (CNT_W'(i) < cnt_q);
    end
  end

  assign pre      = (cnt_q <= pat_len_i) && (&(row_stat_i.hit_here | ~vmask));
  assign pre_sh   = (cnt_m1 <= pat_len_i) && (&(row_stat_i.hit_prev | ~vmask_sh));
  assign match_sh = pre_sh && (pat_len_i != '0) && (cnt_m1 == pat_len_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    ridx_d      = ridx_q;
    res_valid_d = res_valid_q && !res_ready_i;
    ob_d        = ob_q;
    ov_d        = ov_q;
    rl_d        = rl_q;
    oe_d        = oe_q;
    row_ctrl_o.load     = 1'b0;
    row_ctrl_o.shift    = 1'b0;
    row_ctrl_o.load_idx = cnt_q[IDX_W-1:0];
    emit   = 1'b0;
    e_val  = 1'b1;
    e_last = 1'b0;
    e_byte = row_stat_i.head;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          row_ctrl_o.load = 1'b1;
          if (clear_i) begin
            // pattern rewrite on the same edge: the new byte starts an empty window
            row_ctrl_o.load_idx = '0;
            cnt_d = CNT_W'(1);
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          end_d   = in_end_i;
          state_d = S_SCAN;
        end else if (clear_i) begin
          cnt_d = '0;
        end
      end
      S_SCAN: begin
        if (cnt_q != '0 && !pre) begin
          if (out_free) begin
            emit   = 1'b1;
            e_last = pre_sh && !(match_sh && rep_nz)
                     && !(end_q && !match_sh && cnt_m1 != '0);
            row_ctrl_o.shift = 1'b1;
            cnt_d  = cnt_m1;
          end
        end else if (pat_len_i != '0 && cnt_q == pat_len_i) begin
          cnt_d  = '0;
          ridx_d = '0;
          if (rep_nz) begin
            state_d = S_REPL;
          end else if (end_q) begin
            state_d = S_MARK;
          end else begin
            state_d = S_IDLE;
          end
        end else if (end_q && cnt_q != '0) begin
          state_d = S_FLUSH;
        end else begin
          state_d = S_IDLE;
          if (clear_i) begin
            cnt_d = '0;
          end
        end
      end
      S_REPL: begin
        if (out_free) begin
          emit   = 1'b1;
          e_byte = rep_bytes_i[ridx_q*BYTE_W +: BYTE_W];
          e_last = ({1'b0, ridx_q} == rep_len_i - LEN_W'(1));
          ridx_d = ridx_q + IDX_W'(1);
          if (e_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit   = 1'b1;
          e_last = (cnt_q == CNT_W'(1));
          row_ctrl_o.shift = 1'b1;
          cnt_d  = cnt_m1;
          if (e_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_MARK: begin
        if (out_free) begin
          emit    = 1'b1;
          e_byte  = '0;
          e_val   = 1'b0;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase

    if (emit) begin
      res_valid_d = 1'b1;
      ob_d = e_byte;
      ov_d = e_val;
      rl_d = e_last;
      oe_d = end_q && e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      end_q       <= 1'b0;
      ridx_q      <= '0;
      res_valid_q <= 1'b0;
      ob_q        <= '0;
      ov_q        <= 1'b0;
      rl_q        <= 1'b0;
      oe_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      end_q       <= end_d;
      ridx_q      <= ridx_d;
      res_valid_q <= res_valid_d;
      ob_q        <= ob_d;
      ov_q        <= ov_d;
      rl_q        <= rl_d;
      oe_q        <= oe_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign out_byte_o  = ob_q;
  assign out_valid_o = ov_q;
  assign run_last_o  = rl_q;
  assign out_end_o   = oe_q;

  // room for one more byte whenever a new beat can be taken
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> cnt_q < CNT_W'(CELLS))
    else $error("window full while idle");

  // replacement only runs with the window cleared
  a_repl_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REPL |-> cnt_q == '0)
    else $error("window not cleared during replacement");

  a_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(row_ctrl_o.load && row_ctrl_o.shift))
    else $error("cell row loaded and shifted together");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && oe_q |-> rl_q)
    else $error("end of string not on last result");

  a_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !ov_q |-> rl_q && oe_q)
    else $error("empty marker without end flags");

endmodule

// ===== hdl/substring_replace_stream.sv =====
// top level of the streaming find-and-replace block: config registers, cell row, sequencer
// depends on srs_pkg, srs_cell and srs_seq
//
//  channel   handshake                 payload
//  input     in_valid_i / in_ready_o   in_byte_i, in_end_i
//  result    res_valid_o / res_ready_i out_byte_o, out_valid_o, run_last_o, out_end_o
//  config    cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// an input beat causes n results (0 to 8): the byte is loaded into the cell row, the scan
// state shifts out bytes that leave the pattern prefix and then decides on the rest
// result bytes leave one per cycle through the single result register unless it stalls,
// paced by the one-position shift of the cell chain or the replacement index
// a stalled result register holds the sequencer; no input is taken until all results
// of the previous beat are in the register
// reset clears the window count and config registers; no clearing pass
module substring_replace_stream (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [srs_pkg::BYTE_W-1:0]     in_byte_i,
  input  logic                           in_end_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [srs_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           out_valid_o,
  output logic                           run_last_o,
  output logic                           out_end_o,
  input  logic                           cfg_we_i,
  input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import srs_pkg::*;

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_bytes_q, pat_bytes_d;
  logic [LEN_W-1:0]      pat_len_q, pat_len_d;
  logic [CFG_DATA_W-1:0] rep_bytes_q, rep_bytes_d;
  logic [LEN_W-1:0]      rep_len_q, rep_len_d;
  logic                  clear;

  logic [LEN_W-1:0] pat_len_eff, rep_len_eff;

  row_ctrl_t row_ctrl;
  row_stat_t row_stat;

  logic [BYTE_W-1:0] cell_byte [CELLS];

  always_comb begin
    pat_bytes_d = pat_bytes_q;
    pat_len_d   = pat_len_q;
    rep_bytes_d = rep_bytes_q;
    rep_len_d   = rep_len_q;
    clear       = 1'b0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PAT_BYTES: begin
          pat_bytes_d = cfg_data_i;
          clear       = 1'b1;  // new pattern drops pending window bytes
        end
        REG_PAT_LEN: begin
          pat_len_d = cfg_data_i[LEN_W-1:0];
          clear     = 1'b1;
        end
        REG_REP_BYTES: begin
          rep_bytes_d = cfg_data_i;
        end
        REG_REP_LEN: begin
          rep_len_d = cfg_data_i[LEN_W-1:0];
        end
        default: begin
          clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= '0;
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else begin
      pat_bytes_q <= pat_bytes_d;
      pat_len_q   <= pat_len_d;
      rep_bytes_q <= rep_bytes_d;
      rep_len_q   <= rep_len_d;
    end
  end

  // lengths above the window depth saturate
  assign pat_len_eff = (pat_len_q > LEN_W'(CELLS)) ? LEN_W'(CELLS) : pat_len_q;
  assign rep_len_eff = (rep_len_q > LEN_W'(CELLS)) ? LEN_W'(CELLS) : rep_len_q;

  // row of window cells; cell zero holds the oldest pending byte
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    logic [BYTE_W-1:0] next_byte;
    logic [BYTE_W-1:0] pat_prev;

    if (g == CELLS - 1) begin : g_tail
      assign next_byte = '0;
    end else begin : g_mid
      assign next_byte = cell_byte[g+1];
    end

    // cell zero has no position before it; its shifted compare is masked off
    if (g == 0) begin : g_head
      assign pat_prev = '0;
    end else begin : g_body
      assign pat_prev = pat_bytes_q[(g-1)*BYTE_W +: BYTE_W];
    end

    srs_cell u_cell (
      .clk_i       (clk_i),
      .load_en_i   (row_ctrl.load && (row_ctrl.load_idx == IDX_W'(g))),
      .shift_en_i  (row_ctrl.shift),
      .load_byte_i (in_byte_i),
      .next_byte_i (next_byte),
      .pat_here_i  (pat_bytes_q[g*BYTE_W +: BYTE_W]),
      .pat_prev_i  (pat_prev),
      .byte_o      (cell_byte[g]),
      .hit_here_o  (row_stat.hit_here[g]),
      .hit_prev_o  (row_stat.hit_prev[g])
    );
  end

  assign row_stat.head = cell_byte[0];

  // decides shifts, replacement and flush; owns the result register
  srs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .pat_len_i   (pat_len_eff),
    .rep_len_i   (rep_len_eff),
    .rep_bytes_i (rep_bytes_q),
    .row_stat_i  (row_stat),
    .row_ctrl_o  (row_ctrl),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_end_i    (in_end_i),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .run_last_o  (run_last_o),
    .out_end_o   (out_end_o)
  );

endmodule
